// ===== rtl/debounced_event_window_counter_assert.svh =====
// Assertion macros shared by the counter RTL.
`ifndef DEBOUNCED_EVENT_WINDOW_COUNTER_ASSERT_SVH
`define DEBOUNCED_EVENT_WINDOW_COUNTER_ASSERT_SVH

`ifndef SYNTH
// condition implies consequence in the same cycle
`define DEWC_ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("dewc assertion failed");
// condition implies consequence in the next cycle
`define DEWC_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("dewc assertion failed");
`else
`define DEWC_ASSERT_SAME(label, clk, rst, cond, cons)
`define DEWC_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif

`endif

// ===== rtl/dewc_pkg.sv =====
`timescale 1ns / 1ps
package dewc_pkg;
  localparam int TIME_W       = 48;
  localparam int SECS_W       = 16;
  localparam int DEB_W        = 24;
  localparam int TOTAL_W      = 32;
  localparam int RECENT_W     = 9;
  localparam int PROD_W       = 36;
  localparam int CUT_W        = TIME_W + 1;
  localparam int EXT_W        = 13;   // holds a count up to the largest ring depth
  localparam int RING_DEPTH   = 300;
  localparam logic [DEB_W-1:0]    DEBOUNCE_RESET = 24'd50000;
  localparam logic [19:0]         USEC_PER_SEC   = 20'd1000000;
  localparam logic [EXT_W-1:0]    RECENT_MAX     = 13'd511;
endpackage

// ===== rtl/dewc_cell.sv =====
`timescale 1ns / 1ps
module dewc_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic [dewc_pkg::TIME_W-1:0]  d,
  output logic [dewc_pkg::TIME_W-1:0]  q
);
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end
endmodule

// ===== rtl/dewc_tally.sv =====
`timescale 1ns / 1ps
module dewc_tally #(
  parameter int CNT_W = 9
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               en,
  input  logic [dewc_pkg::TIME_W-1:0]        ts,
  input  logic signed [dewc_pkg::CUT_W-1:0]  cutoff,
  output logic [CNT_W-1:0]                   count
);
  logic signed [dewc_pkg::CUT_W-1:0] ts_s;
  logic                              hit;

  assign ts_s = $signed({1'b0, ts});
  assign hit  = ts_s > cutoff;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (en && hit) begin
      count <= count + CNT_W'(1);
    end
  end
endmodule

// ===== rtl/debounced_event_window_counter.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Fields (low bit up)
// s_axis    in   tuser: mode; tdata: now_time[47:0], window_seconds[63:48]
// m_axis    out  tdata: accepted[0], total_count[32:1], recent_count[41:33], zero
// debounce  in   debounce_we / debounce_data: debounce_time, 24 bits
//
// A knock's result is registered at the accept edge.
// A query does the cutoff subtract after the product, then scans while the
// cell ring rotates once past the comparator at its tail. The output register
// holds one result; a new item is taken when no query is running and that
// register is empty or being drained.
// Synchronous reset clears every timestamp cell, the totals and the handshake.
module debounced_event_window_counter #(
  parameter int RING_DEPTH = dewc_pkg::RING_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,   // now_time, window_seconds
  input  logic                        s_tuser,   // mode
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [47:0]                 m_tdata,   // accepted, total_count, recent_count
  input  logic                        debounce_we,
  input  logic [dewc_pkg::DEB_W-1:0]  debounce_data
);
  `include "debounced_event_window_counter_assert.svh"

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int IDX_W = $clog2(RING_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CUT  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                         state;
  logic [IDX_W-1:0]                   scan_idx;
  logic [dewc_pkg::DEB_W-1:0]         debounce;
  logic [dewc_pkg::TIME_W-1:0]        last_time;
  logic [dewc_pkg::TOTAL_W-1:0]       total;
  logic [dewc_pkg::TIME_W-1:0]        now_q;
  logic [dewc_pkg::PROD_W-1:0]        prod;
  logic signed [dewc_pkg::CUT_W-1:0]  cutoff;

  logic                               out_acc;
  logic [dewc_pkg::TOTAL_W-1:0]       out_total;
  logic [dewc_pkg::RECENT_W-1:0]      out_recent;

  logic [dewc_pkg::TIME_W-1:0]        in_now;
  logic [dewc_pkg::SECS_W-1:0]        in_secs;
  logic                               take;
  logic                               knock_pass;
  logic                               knock_store;
  logic                               scanning;
  logic                               out_free;
  logic [dewc_pkg::TIME_W-1:0]        head_d;
  logic [dewc_pkg::TIME_W-1:0]        cell_q [RING_DEPTH];
  logic [CNT_W-1:0]                   count;
  logic [dewc_pkg::EXT_W-1:0]         count_ext;
  logic [dewc_pkg::RECENT_W-1:0]      recent_sat;

  assign in_now   = s_tdata[47:0];
  assign in_secs  = s_tdata[63:48];
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign take     = s_tvalid && s_tready;
  assign scanning = (state == ST_SCAN);

  assign knock_pass  = (in_now >= last_time) &&
                       ((in_now - last_time) >= {24'd0, debounce});
  assign knock_store = take && !s_tuser && knock_pass;

  // new knock enters at the head, the oldest drops off the tail
  assign head_d = knock_store ? in_now : cell_q[RING_DEPTH-1];

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_ring
    if (i == 0) begin : g_head
      dewc_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (knock_store || scanning),
        .d     (head_d),
        .q     (cell_q[i])
      );
    end else begin : g_body
      dewc_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (knock_store || scanning),
        .d     (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  dewc_tally #(.CNT_W(CNT_W)) u_tally (
    .clk    (clk),
    .rst    (rst),
    .clear  (state == ST_CUT),
    .en     (scanning),
    .ts     (cell_q[RING_DEPTH-1]),
    .cutoff (cutoff),
    .count  (count)
  );

  assign count_ext  = dewc_pkg::EXT_W'(count);
  assign recent_sat = (count_ext > dewc_pkg::RECENT_MAX) ? '1 : count_ext[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= dewc_pkg::DEBOUNCE_RESET;
    end else if (debounce_we) begin
      debounce <= debounce_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_idx  <= '0;
      last_time <= '0;
      total     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (s_tuser) begin
              state <= ST_CUT;
            end else begin
              m_tvalid <= 1'b1;
              if (knock_pass) begin
                last_time <= in_now;
                total     <= total + 32'd1;
              end
            end
          end
        end
        ST_CUT: begin
          scan_idx <= '0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_idx == IDX_W'(RING_DEPTH - 1)) begin
            state <= ST_DONE;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      now_q <= in_now;
      prod  <= dewc_pkg::PROD_W'(in_secs) * dewc_pkg::PROD_W'(dewc_pkg::USEC_PER_SEC);
    end
    if (state == ST_CUT) begin
      cutoff <= $signed({1'b0, now_q}) - $signed({13'd0, prod});
    end
    if (take && !s_tuser) begin
      out_acc    <= knock_pass;
      out_total  <= knock_pass ? total + 32'd1 : total;
      out_recent <= '0;
    end else if (state == ST_DONE && out_free) begin
      out_acc    <= 1'b0;
      out_total  <= total;
      out_recent <= recent_sat;
    end
  end

  assign m_tdata = {6'd0, out_recent, out_total, out_acc};

  `DEWC_ASSERT_SAME(a_busy_no_take, clk, rst, state != ST_IDLE, !s_tready)
  `DEWC_ASSERT_NEXT(a_knock_result, clk, rst, take && !s_tuser, m_tvalid)
  `DEWC_ASSERT_NEXT(a_query_starts, clk, rst, take && s_tuser, state == ST_CUT)
  `DEWC_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(RING_DEPTH))
endmodule
